// File: src/velocity_verlet_particle_update_core_assert.svh
// assertion macros used by the checker file
// no dependencies; include guard keeps it single
`ifndef VELOCITY_VERLET_PARTICLE_UPDATE_CORE_ASSERT_SVH
`define VELOCITY_VERLET_PARTICLE_UPDATE_CORE_ASSERT_SVH

// same-cycle implication under synchronous reset
`define VVPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under synchronous reset
`define VVPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/vvpu_pkg.sv
// shared constants for the velocity verlet particle update core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vvpu_pkg;

   localparam int unsigned CSR_DATA_W  = 31;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned DIV_STEPS   = 62;
   localparam int unsigned SQRT_STEPS  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_SKIN = 1'd1;

   localparam logic [CSR_DATA_W-1:0] TIME_STEP_RESET = 31'd655;
   localparam logic [CSR_DATA_W-1:0] HALF_SKIN_RESET = 31'd9830;

   localparam logic [30:0] MAX31 = 31'h7fff_ffff;

endpackage

`default_nettype wire

// File: src/velocity_verlet_particle_update_core.sv
// velocity verlet particle update: one particle per transaction, 3 axes
// depends on vvpu_pkg
// kind 0: per axis multiply, divide, kick, multiply, drift, square and sum; then max, and sqrt and total on a last item
// kind 1: per axis multiply, divide and kick only; one transaction in flight, back to idle after the result is taken
// rate is set by the bit-serial 62-step divider per axis and the 32-step sqrt
// reset (synchronous, active high) restores dt and half skin and clears state
`timescale 1ns / 1ps
`default_nettype none

module velocity_verlet_particle_update_core
   import vvpu_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_kind,
   input  wire logic [31:0]             req_mass,
   input  wire logic signed [31:0]      req_force_x,
   input  wire logic signed [31:0]      req_force_y,
   input  wire logic signed [31:0]      req_force_z,
   input  wire logic signed [31:0]      req_vel_x,
   input  wire logic signed [31:0]      req_vel_y,
   input  wire logic signed [31:0]      req_vel_z,
   input  wire logic signed [31:0]      req_pos_x,
   input  wire logic signed [31:0]      req_pos_y,
   input  wire logic signed [31:0]      req_pos_z,
   input  wire logic                    req_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [31:0]           rsp_new_vel_x,
   output logic signed [31:0]           rsp_new_vel_y,
   output logic signed [31:0]           rsp_new_vel_z,
   output logic signed [31:0]           rsp_new_pos_x,
   output logic signed [31:0]           rsp_new_pos_y,
   output logic signed [31:0]           rsp_new_pos_z,
   output logic [30:0]                  rsp_pass_move,
   output logic                         rsp_resort,
   output logic                         rsp_end_of_group
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_F, ST_DIV, ST_KICK, ST_MUL_V, ST_DRIFT,
      ST_SQ, ST_ACC, ST_MAX, ST_SQRT, ST_TOTAL, ST_OUT
   } state_type;

   // sequencer
   state_type         state_ff, state_in;
   logic [1:0]        axis_ff, axis_in;
   logic [5:0]        cnt_ff, cnt_in;
   // captured transaction
   logic              kind_ff, kind_in;
   logic              last_ff, last_in;
   logic [32:0]       div_ff, div_in;
   logic signed [31:0] f_ff [NUM_AXES];
   logic signed [31:0] f_in [NUM_AXES];
   logic signed [31:0] v_ff [NUM_AXES];
   logic signed [31:0] v_in [NUM_AXES];
   logic signed [31:0] p_ff [NUM_AXES];
   logic signed [31:0] p_in [NUM_AXES];
   // results
   logic signed [31:0] nv_ff [NUM_AXES];
   logic signed [31:0] nv_in [NUM_AXES];
   logic signed [31:0] np_ff [NUM_AXES];
   logic signed [31:0] np_in [NUM_AXES];
   logic [30:0]       move_ff, move_in;
   logic              resort_ff, resort_in;
   // datapath
   logic [61:0]       dvd_ff, dvd_in;
   logic [32:0]       rem_ff, rem_in;
   logic [63:0]       prod_ff, prod_in;
   logic [30:0]       dmc_ff, dmc_in;
   logic [63:0]       sq_ff, sq_in;
   logic [63:0]       rt_x_ff, rt_x_in;
   logic [33:0]       rt_rem_ff, rt_rem_in;
   logic [31:0]       rt_r_ff, rt_r_in;
   // persistent state
   logic [63:0]       max_ff, max_in;
   logic [31:0]       moved_ff, moved_in;
   logic [30:0]       dt_ff, dt_in;
   logic [30:0]       hs_ff, hs_in;

   // shared multiplier
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;

   // per-axis views
   logic signed [31:0] f_cur, v_cur, p_cur, nv_cur;
   logic [31:0]       f_mag, nv_mag;

   // divider step
   logic [33:0]       div_shift;
   logic [34:0]       div_diff;

   // kick and drift sums
   logic signed [63:0] kick_sum;
   logic signed [47:0] drift_sum;
   logic [45:0]       drift_mag;

   // sqrt step
   logic [35:0]       rt_shift;
   logic [36:0]       rt_diff;

   // end of pass
   logic [63:0]       max_new;
   logic [30:0]       move_sat;
   logic [32:0]       total_raw;
   logic [31:0]       total_sat;

   function automatic logic signed [31:0] sat_from64(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] sat_from48(input logic signed [47:0] x);
      if (x > 48'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (x < -48'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   assign f_cur  = f_ff[axis_ff];
   assign v_cur  = v_ff[axis_ff];
   assign p_cur  = p_ff[axis_ff];
   assign nv_cur = nv_ff[axis_ff];
   // magnitude of the most negative value still fits unsigned 32 bits
   assign f_mag  = f_cur[31] ? (32'd0 - f_cur) : f_cur;
   assign nv_mag = nv_cur[31] ? (32'd0 - nv_cur) : nv_cur;

   // operand select for the one 32x32 multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL_F: begin
            mul_a = {1'b0, dt_ff};
            mul_b = f_mag;
         end
         ST_MUL_V: begin
            mul_a = {1'b0, dt_ff};
            mul_b = nv_mag;
         end
         ST_SQ: begin
            mul_a = {1'b0, dmc_ff};
            mul_b = {1'b0, dmc_ff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // restoring division: one quotient bit per cycle
   assign div_shift = {rem_ff, dvd_ff[61]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, div_ff};

   // kick: v + sign(f) * floor(dt*|f| / 2m)
   always_comb begin
      if (f_cur[31]) begin
         kick_sum = 64'(v_cur) - $signed({2'b00, dvd_ff});
      end else begin
         kick_sum = 64'(v_cur) + $signed({2'b00, dvd_ff});
      end
   end

   // drift: p + sign(v') * floor(dt*|v'| / 2^16)
   assign drift_mag = prod_ff[61:16];
   always_comb begin
      if (nv_cur[31]) begin
         drift_sum = 48'(p_cur) - $signed({2'b00, drift_mag});
      end else begin
         drift_sum = 48'(p_cur) + $signed({2'b00, drift_mag});
      end
   end

   // digit-by-digit square root, two radicand bits per cycle
   assign rt_shift = {rt_rem_ff, rt_x_ff[63:62]};
   assign rt_diff  = {1'b0, rt_shift} - {3'b000, rt_r_ff, 2'b01};

   assign max_new   = (sq_ff > max_ff) ? sq_ff : max_ff;
   assign move_sat  = rt_r_ff[31] ? MAX31 : rt_r_ff[30:0];
   assign total_raw = {1'b0, moved_ff} + {2'b00, move_sat};
   assign total_sat = total_raw[32] ? 32'hffff_ffff : total_raw[31:0];

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      div_in    = div_ff;
      f_in      = f_ff;
      v_in      = v_ff;
      p_in      = p_ff;
      nv_in     = nv_ff;
      np_in     = np_ff;
      move_in   = move_ff;
      resort_in = resort_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      prod_in   = prod_ff;
      dmc_in    = dmc_ff;
      sq_in     = sq_ff;
      rt_x_in   = rt_x_ff;
      rt_rem_in = rt_rem_ff;
      rt_r_in   = rt_r_ff;
      max_in    = max_ff;
      moved_in  = moved_ff;
      dt_in     = dt_ff;
      hs_in     = hs_ff;

      // the user must write configuration only while idle; the block itself does not enforce it
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_TIME_STEP: dt_in = csr_write_data;
            REG_HALF_SKIN: hs_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               last_in   = req_last;
               // zero mass counts as one lsb
               div_in    = (req_mass == 32'd0) ? 33'd2 : {req_mass, 1'b0};
               f_in[0]   = req_force_x;
               f_in[1]   = req_force_y;
               f_in[2]   = req_force_z;
               v_in[0]   = req_vel_x;
               v_in[1]   = req_vel_y;
               v_in[2]   = req_vel_z;
               p_in[0]   = req_pos_x;
               p_in[1]   = req_pos_y;
               p_in[2]   = req_pos_z;
               move_in   = 31'd0;
               resort_in = 1'b0;
               sq_in     = 64'd0;
               axis_in   = 2'd0;
               state_in  = ST_MUL_F;
            end
         end
         ST_MUL_F: begin
            // product goes straight into the dividend shifter
            dvd_in   = mul_p[61:0];
            rem_in   = 33'd0;
            cnt_in   = 6'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_diff[34]) begin
               rem_in = div_diff[32:0];
            end else begin
               rem_in = div_shift[32:0];
            end
            dvd_in = {dvd_ff[60:0], ~div_diff[34]};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_KICK;
            end
         end
         ST_KICK: begin
            nv_in[axis_ff] = sat_from64(kick_sum);
            if (kind_ff) begin
               np_in[axis_ff] = p_cur;
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  state_in = ST_OUT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MUL_F;
               end
            end else begin
               state_in = ST_MUL_V;
            end
         end
         ST_MUL_V: begin
            prod_in  = mul_p;
            state_in = ST_DRIFT;
         end
         ST_DRIFT: begin
            np_in[axis_ff] = sat_from48(drift_sum);
            dmc_in   = (drift_mag > 46'(MAX31)) ? MAX31 : drift_mag[30:0];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            prod_in  = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sq_in = sq_ff + prod_ff;
            if (axis_ff == 2'(NUM_AXES - 1)) begin
               state_in = ST_MAX;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_MUL_F;
            end
         end
         ST_MAX: begin
            max_in = max_new;
            if (last_ff) begin
               rt_x_in   = max_new;
               rt_rem_in = 34'd0;
               rt_r_in   = 32'd0;
               cnt_in    = 6'(SQRT_STEPS - 1);
               state_in  = ST_SQRT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SQRT: begin
            if (!rt_diff[36]) begin
               rt_rem_in = rt_diff[33:0];
            end else begin
               rt_rem_in = rt_shift[33:0];
            end
            rt_r_in = {rt_r_ff[30:0], ~rt_diff[36]};
            rt_x_in = {rt_x_ff[61:0], 2'b00};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            move_in = move_sat;
            max_in  = 64'd0;
            if (total_sat > {1'b0, hs_ff}) begin
               resort_in = 1'b1;
               moved_in  = 32'd0;
            end else begin
               moved_in = total_sat;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff   <= 64'd0;
         moved_ff <= 32'd0;
         dt_ff    <= TIME_STEP_RESET;
         hs_ff    <= HALF_SKIN_RESET;
      end else begin
         state_ff <= state_in;
         max_ff   <= max_in;
         moved_ff <= moved_in;
         dt_ff    <= dt_in;
         hs_ff    <= hs_in;
      end
   end

   // payload and datapath registers, no reset
   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      cnt_ff    <= cnt_in;
      kind_ff   <= kind_in;
      last_ff   <= last_in;
      div_ff    <= div_in;
      f_ff      <= f_in;
      v_ff      <= v_in;
      p_ff      <= p_in;
      nv_ff     <= nv_in;
      np_ff     <= np_in;
      move_ff   <= move_in;
      resort_ff <= resort_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      prod_ff   <= prod_in;
      dmc_ff    <= dmc_in;
      sq_ff     <= sq_in;
      rt_x_ff   <= rt_x_in;
      rt_rem_ff <= rt_rem_in;
      rt_r_ff   <= rt_r_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_new_vel_x    = nv_ff[0];
   assign rsp_new_vel_y    = nv_ff[1];
   assign rsp_new_vel_z    = nv_ff[2];
   assign rsp_new_pos_x    = np_ff[0];
   assign rsp_new_pos_y    = np_ff[1];
   assign rsp_new_pos_z    = np_ff[2];
   assign rsp_pass_move    = move_ff;
   assign rsp_resort       = resort_ff;
   assign rsp_end_of_group = last_ff;

endmodule

`default_nettype wire

// File: src/vvpu_checker.sv
// port-level checks for the velocity verlet particle update core, with bind
// depends on vvpu_pkg and velocity_verlet_particle_update_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_verlet_particle_update_core_assert.svh"

module vvpu_checker
   import vvpu_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [30:0] rsp_pass_move,
   input wire logic        rsp_resort,
   input wire logic        rsp_end_of_group
);

   // one transaction in flight: never taking and showing at once
   `VVPU_ASSERT_NOW(a_excl, clock, reset, rsp_valid, !req_ready, "ready while result shown")

   `VVPU_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready after take")

   `VVPU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

   // pass summary only closes a group
   `VVPU_ASSERT_NOW(a_move, clock, reset, rsp_valid && (rsp_resort || rsp_pass_move != 31'd0), rsp_end_of_group, "summary off group end")

endmodule

bind velocity_verlet_particle_update_core vvpu_checker u_vvpu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_pass_move    (rsp_pass_move),
   .rsp_resort       (rsp_resort),
   .rsp_end_of_group (rsp_end_of_group)
);

`default_nettype wire
